// ===== hw/rtl/ffba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int DEF_MAX_BLOCKS     = 64;
  localparam int DEF_HEADER_BYTES   = 24;
  localparam int DEF_HEAP_ADDR_BITS = 20;

  localparam int FIELD_W  = 20;
  localparam int STATUS_W = 3;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [FIELD_W-1:0] LIMIT_RESET = '1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_AW-3:0] REG_HEAP_LIMIT = '0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_DOUBLE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               opcode;
    logic [FIELD_W-1:0] request_size;
    logic [FIELD_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic vld;
    logic hit;
    logic dbl;
  } pkt_ctl_t;

endpackage

// ===== hw/rtl/ffba_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface ffba_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [ffba_pkg::FIELD_W-1:0] request_size;
  logic [ffba_pkg::FIELD_W-1:0] free_address;

  modport source (output valid, opcode, request_size, free_address, input ready);
  modport sink (input valid, opcode, request_size, free_address, output ready);
endinterface

interface ffba_out_if;
  logic                          valid;
  logic                          ready;
  logic [ffba_pkg::STATUS_W-1:0] status;
  logic [ffba_pkg::FIELD_W-1:0]  payload_address;
  logic                          reused;

  modport source (output valid, status, payload_address, reused, input ready);
  modport sink (input valid, status, payload_address, reused, output ready);
endinterface

// ===== hw/rtl/ffba_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_cell
// One block table entry; checks the passing search word and hands it on.
// ----------------------------------------------------------------------------
module ffba_cell #(
  parameter int IDX          = 0,
  parameter int CW           = 7,
  parameter int AW           = 20,
  parameter int HEADER_BYTES = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ffba_pkg::req_t               req,
  input  logic [CW-1:0]                count,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_base,
  input  logic [ffba_pkg::FIELD_W-1:0] wr_len,
  input  ffba_pkg::pkt_ctl_t           pin,
  input  logic [AW-1:0]                pin_base,
  output ffba_pkg::pkt_ctl_t           pout,
  output logic [AW-1:0]                pout_base
);

  localparam int CMP_W = ((AW > ffba_pkg::FIELD_W) ? AW : ffba_pkg::FIELD_W) + 2;

  logic [AW-1:0]                base_r;
  logic [ffba_pkg::FIELD_W-1:0] len_r;
  logic                         free_r;
  ffba_pkg::pkt_ctl_t           pout_r;
  ffba_pkg::pkt_ctl_t           pout_nxt;
  logic [AW-1:0]                pout_base_r;
  logic [AW-1:0]                pout_base_nxt;

  logic in_use;
  logic wr_sel;
  logic len_ge;
  logic addr_eq;
  logic hit_here;
  logic is_free_op;

  assign in_use     = CW'(IDX) < count;
  assign wr_sel     = wr_en && (count == CW'(IDX));
  assign is_free_op = (req.opcode == ffba_pkg::OP_FREE);
  assign len_ge     = len_r >= req.request_size;
  assign addr_eq    = (CMP_W'(base_r) + CMP_W'(HEADER_BYTES)) == CMP_W'(req.free_address);
  assign hit_here   = pin.vld && !pin.hit && in_use &&
                      (is_free_op ? addr_eq : (free_r && len_ge));

  always_comb begin
    pout_nxt.vld  = pin.vld;
    pout_nxt.hit  = pin.hit | hit_here;
    pout_nxt.dbl  = pin.dbl | (hit_here && is_free_op && free_r);
    pout_base_nxt = hit_here ? base_r : pin_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pout_r <= '0;
    end else begin
      pout_r <= pout_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pout_base_r <= pout_base_nxt;
    if (wr_sel) begin
      base_r <= wr_base;
      len_r  <= wr_len;
      free_r <= 1'b0;
    end else if (hit_here) begin
      free_r <= is_free_op;
    end
  end

  assign pout      = pout_r;
  assign pout_base = pout_base_r;

endmodule

// ===== hw/rtl/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// flow: an accepted word is registered and walks the row of table cells one cell
//   per cycle; the result is registered when it leaves the row, and no new word is
//   accepted until that result has been handed to the output register
// reset: synchronous active low; clears block count, heap top, heap limit
//   to all ones; table entries are not cleared
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocate/free over a block table held in a chain of cells.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS     = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES   = ffba_pkg::DEF_HEADER_BYTES,
  parameter int HEAP_ADDR_BITS = ffba_pkg::DEF_HEAP_ADDR_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ffba_in_if.sink                     in_ch,
  ffba_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ffba_pkg::CFG_AW-1:0] paddr,
  input  logic [ffba_pkg::CFG_DW-1:0] pwdata,
  output logic [ffba_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  localparam int AW    = HEAP_ADDR_BITS;
  localparam int CW    = $clog2(MAX_BLOCKS + 1);
  localparam int FW    = ffba_pkg::FIELD_W;
  localparam int CMP_W = ((AW > FW) ? AW : FW) + 2;
  localparam logic [CMP_W-1:0] ADDR_MASK = CMP_W'((64'd1 << AW) - 64'd1);

  ffba_pkg::state_t   state_r;
  ffba_pkg::state_t   state_nxt;
  ffba_pkg::req_t     req_r;
  ffba_pkg::pkt_ctl_t inj_r;
  ffba_pkg::pkt_ctl_t inj_nxt;
  logic [CW-1:0]      count_r;
  logic [AW-1:0]      top_r;
  logic [FW-1:0]      limit_r;
  logic               hit_r;
  logic               dbl_r;
  logic [AW-1:0]      hbase_r;

  logic                        out_vld_r;
  logic [ffba_pkg::STATUS_W-1:0] out_status_r;
  logic [FW-1:0]               out_addr_r;
  logic                        out_reused_r;

  ffba_pkg::pkt_ctl_t chain_c [MAX_BLOCKS+1];
  logic [AW-1:0]      chain_b [MAX_BLOCKS+1];

  logic             in_acc;
  logic             emit;
  logic             wr_en;
  logic             skip;
  logic             cfg_wr;
  logic [CMP_W-1:0] limit_eff;
  logic [CMP_W-1:0] new_top;
  logic [CMP_W-1:0] res_addr;
  ffba_pkg::status_t res_status;
  logic             res_reused;
  logic             append;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[ffba_pkg::CFG_AW-1:2] == ffba_pkg::REG_HEAP_LIMIT);

  always_comb begin
    unique case (paddr[ffba_pkg::CFG_AW-1:2])
      ffba_pkg::REG_HEAP_LIMIT: prdata = ffba_pkg::CFG_DW'(limit_r);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= ffba_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_r <= pwdata[FW-1:0];
    end
  end

  // cell row
  assign chain_c[0] = inj_r;
  assign chain_b[0] = '0;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    ffba_cell #(
      .IDX          (g),
      .CW           (CW),
      .AW           (AW),
      .HEADER_BYTES (HEADER_BYTES)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .req       (req_r),
      .count     (count_r),
      .wr_en     (wr_en),
      .wr_base   (top_r),
      .wr_len    (req_r.request_size),
      .pin       (chain_c[g]),
      .pin_base  (chain_b[g]),
      .pout      (chain_c[g+1]),
      .pout_base (chain_b[g+1])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffba_pkg::S_IDLE: if (in_ch.valid) state_nxt = ffba_pkg::S_SCAN;
      ffba_pkg::S_SCAN: if (chain_c[MAX_BLOCKS].vld) state_nxt = ffba_pkg::S_DONE;
      ffba_pkg::S_DONE: if (!out_vld_r || out_ch.ready) state_nxt = ffba_pkg::S_IDLE;
      default:          state_nxt = ffba_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    emit        = 1'b0;
    unique case (state_r)
      ffba_pkg::S_IDLE: in_ch.ready = 1'b1;
      ffba_pkg::S_SCAN: ;
      ffba_pkg::S_DONE: emit = !out_vld_r || out_ch.ready;
      default: ;
    endcase
  end

  assign in_acc = in_ch.valid && in_ch.ready;
  assign skip   = (in_ch.opcode == ffba_pkg::OP_ALLOC) ?
                  (in_ch.request_size == '0) : (in_ch.free_address == '0);

  always_comb begin
    inj_nxt.vld = in_acc;
    inj_nxt.hit = skip;
    inj_nxt.dbl = 1'b0;
  end

  // result decision
  assign limit_eff = (CMP_W'(limit_r) > ADDR_MASK) ? ADDR_MASK : CMP_W'(limit_r);
  assign new_top   = CMP_W'(top_r) + CMP_W'(HEADER_BYTES) + CMP_W'(req_r.request_size);

  always_comb begin
    res_status = ffba_pkg::ST_OK;
    res_addr   = '0;
    res_reused = 1'b0;
    append     = 1'b0;
    if (req_r.opcode == ffba_pkg::OP_FREE) begin
      if (req_r.free_address == '0) begin
        res_status = ffba_pkg::ST_OK;
      end else if (!hit_r) begin
        res_status = ffba_pkg::ST_UNKNOWN;
      end else if (dbl_r) begin
        res_status = ffba_pkg::ST_DOUBLE;
      end
    end else if (req_r.request_size == '0) begin
      res_status = ffba_pkg::ST_ZERO;
    end else if (hit_r) begin
      res_addr   = CMP_W'(hbase_r) + CMP_W'(HEADER_BYTES);
      res_reused = 1'b1;
    end else if ((count_r == CW'(MAX_BLOCKS)) || (new_top > limit_eff)) begin
      res_status = ffba_pkg::ST_NOSPACE;
    end else begin
      res_addr = CMP_W'(top_r) + CMP_W'(HEADER_BYTES);
      append   = 1'b1;
    end
  end

  assign wr_en = emit && append;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ffba_pkg::S_IDLE;
      inj_r     <= '0;
      count_r   <= '0;
      top_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      inj_r   <= inj_nxt;
      if (wr_en) begin
        count_r <= count_r + CW'(1);
        top_r   <= new_top[AW-1:0];
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r.opcode       <= in_ch.opcode;
      req_r.request_size <= in_ch.request_size;
      req_r.free_address <= in_ch.free_address;
    end
    if (chain_c[MAX_BLOCKS].vld) begin
      hit_r   <= chain_c[MAX_BLOCKS].hit;
      dbl_r   <= chain_c[MAX_BLOCKS].dbl;
      hbase_r <= chain_b[MAX_BLOCKS];
    end
    if (emit) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr[FW-1:0];
      out_reused_r <= res_reused;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.payload_address = out_addr_r;
  assign out_ch.reused          = out_reused_r;

`ifndef SYNTHESIS
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ffba_pkg::S_SCAN)
    else $error("accepted word did not start a scan");

  a_tail_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chain_c[MAX_BLOCKS].vld |-> state_r == ffba_pkg::S_SCAN)
    else $error("search word left the row outside a scan");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_BLOCKS))
    else $error("block count beyond table depth");

  a_reused_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_reused_r |-> out_status_r == ffba_pkg::ST_OK)
    else $error("reused block with failing status");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit block allocator. Request words are
// driven on the input channel with random gaps, result words are drained with
// random stalls, and each result is compared field by field against a local
// model of the block table, heap top and heap limit. The heap limit register
// is written over the APB port between phases, from zero up to its maximum.
// ----------------------------------------------------------------------------
module tb_top;
  import ffba_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int MAX_BLOCKS     = DEF_MAX_BLOCKS;
  localparam int HEADER_BYTES   = DEF_HEADER_BYTES;
  localparam int HEAP_ADDR_BITS = DEF_HEAP_ADDR_BITS;
  localparam logic [FIELD_W-1:0] FIELD_MAX  = '1;
  localparam logic [CFG_AW-1:0]  LIMIT_ADDR = {REG_HEAP_LIMIT, 2'b00};

  typedef struct packed {
    status_t            status;
    logic [FIELD_W-1:0] addr;
    logic               reused;
  } outcome_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  ffba_in_if  in_ch ();
  ffba_out_if out_ch ();

  first_fit_block_allocator #(
    .MAX_BLOCKS     (MAX_BLOCKS),
    .HEADER_BYTES   (HEADER_BYTES),
    .HEAP_ADDR_BITS (HEAP_ADDR_BITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_HALF) clk = ~clk;

  // local copy of the allocator state
  logic [FIELD_W-1:0] blk_base [MAX_BLOCKS];
  logic [FIELD_W-1:0] blk_len  [MAX_BLOCKS];
  logic               blk_free [MAX_BLOCKS];
  int unsigned        blk_count;
  logic [FIELD_W-1:0] heap_top_sh;
  logic [FIELD_W-1:0] limit_sh;

  outcome_t outcome_q[$];
  bit       burst_mode;
  int       n_errors;
  int       n_words;
  int       n_fresh;
  int       n_reused;
  int       n_nospace;
  int       n_zero;
  int       n_unknown;
  int       n_double;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    n_errors++;
  endtask

  function automatic outcome_t heap_outcome(input logic op,
                                            input logic [FIELD_W-1:0] size,
                                            input logic [FIELD_W-1:0] faddr);
    outcome_t    o;
    int unsigned new_top;
    o.status = ST_OK;
    o.addr   = '0;
    o.reused = 1'b0;
    if (op == OP_ALLOC) begin
      if (size == '0) begin
        o.status = ST_ZERO;
        return o;
      end
      for (int i = 0; i < blk_count; i++) begin
        if (blk_free[i] && blk_len[i] >= size) begin
          blk_free[i] = 1'b0;
          o.addr      = FIELD_W'(blk_base[i] + HEADER_BYTES);
          o.reused    = 1'b1;
          return o;
        end
      end
      new_top = heap_top_sh + HEADER_BYTES + size;
      if (blk_count >= MAX_BLOCKS || new_top > limit_sh) begin
        o.status = ST_NOSPACE;
        return o;
      end
      blk_base[blk_count] = heap_top_sh;
      blk_len[blk_count]  = size;
      blk_free[blk_count] = 1'b0;
      blk_count++;
      o.addr      = FIELD_W'(heap_top_sh + HEADER_BYTES);
      heap_top_sh = FIELD_W'(new_top);
    end else begin
      if (faddr == '0) return o;
      for (int i = 0; i < blk_count; i++) begin
        if (blk_base[i] + HEADER_BYTES == faddr) begin
          if (blk_free[i]) o.status = ST_DOUBLE;
          else blk_free[i] = 1'b1;
          return o;
        end
      end
      o.status = ST_UNKNOWN;
    end
    return o;
  endfunction

  task automatic send_word(input logic op, input logic [FIELD_W-1:0] size,
                           input logic [FIELD_W-1:0] faddr);
    int       gap;
    outcome_t want;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.request_size <= size;
    in_ch.free_address <= faddr;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    want = heap_outcome(op, size, faddr);
    outcome_q.push_back(want);
    n_words++;
    case (want.status)
      ST_OK: begin
        if (want.reused) n_reused++;
        else if (op == OP_ALLOC) n_fresh++;
      end
      ST_ZERO:    n_zero++;
      ST_NOSPACE: n_nospace++;
      ST_UNKNOWN: n_unknown++;
      ST_DOUBLE:  n_double++;
      default: ;
    endcase
  endtask

  task automatic alloc_word(input logic [FIELD_W-1:0] size);
    send_word(OP_ALLOC, size, FIELD_W'($urandom));
  endtask

  task automatic free_word(input logic [FIELD_W-1:0] faddr);
    send_word(OP_FREE, FIELD_W'($urandom), faddr);
  endtask

  task automatic release_input;
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [CFG_AW-1:0] addr, output logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_heap_limit(input logic [FIELD_W-1:0] value);
    logic [CFG_DW-1:0] rd;
    release_input;
    wait_drain;
    apb_write(LIMIT_ADDR, CFG_DW'(value));
    limit_sh = value;
    apb_read(LIMIT_ADDR, rd);
    if (rd !== CFG_DW'(value)) report_mismatch("heap_limit readback", rd, CFG_DW'(value));
  endtask

  // mostly well-formed traffic on the live table, plus noise and zero sizes
  task automatic run_random(input int count, input int max_size);
    int          sel;
    int unsigned idx;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      idx = (blk_count > 0) ? $urandom_range(0, blk_count - 1) : 0;
      if (sel < 32) alloc_word(FIELD_W'($urandom_range(1, max_size)));
      else if (sel < 45) begin
        if (blk_count > 0) alloc_word(blk_len[idx] + FIELD_W'($urandom_range(0, 1)));
        else alloc_word(FIELD_W'($urandom_range(1, max_size)));
      end else if (sel < 80) begin
        if (blk_count > 0) free_word(FIELD_W'(blk_base[idx] + HEADER_BYTES));
        else free_word(FIELD_W'($urandom_range(1, 64)));
      end else if (sel < 84) free_word('0);
      else if (sel < 88) free_word(FIELD_W'($urandom));
      else if (sel < 91) begin
        if (blk_count > 0) free_word(FIELD_W'(blk_base[idx] + HEADER_BYTES + 1));
        else free_word(FIELD_MAX);
      end else if (sel < 96) alloc_word(FIELD_W'($urandom));
      else alloc_word('0);
    end
  endtask

  task automatic test_register_access;
    logic [CFG_DW-1:0] rd;
    apb_read(LIMIT_ADDR, rd);
    if (rd !== CFG_DW'(LIMIT_RESET)) report_mismatch("heap_limit reset", rd, CFG_DW'(LIMIT_RESET));
    set_heap_limit(FIELD_W'(20'hA5A5A));
    set_heap_limit(FIELD_W'(20'h5A5A5));
  endtask

  task automatic test_special_cases;
    set_heap_limit(FIELD_W'(200));
    alloc_word('0);
    free_word('0);
    free_word(FIELD_W'(HEADER_BYTES));
    alloc_word(FIELD_W'(1));
    alloc_word(FIELD_MAX);
    free_word(FIELD_W'(HEADER_BYTES));
    free_word(FIELD_W'(HEADER_BYTES));
    alloc_word(FIELD_W'(1));
    alloc_word(FIELD_W'(2));
    free_word(FIELD_W'(HEADER_BYTES + 25));
    alloc_word(FIELD_W'(1));
    free_word(FIELD_W'(20'h80000));
    free_word(FIELD_MAX);
    free_word(FIELD_W'(HEADER_BYTES + 26));
    alloc_word(FIELD_W'(126));
    alloc_word(FIELD_W'(125));
    alloc_word(FIELD_W'(1));
  endtask

  task automatic test_limit_extremes;
    set_heap_limit('0);
    alloc_word(FIELD_W'(1));
    free_word(FIELD_W'(HEADER_BYTES));
    alloc_word(FIELD_W'(1));
    set_heap_limit(FIELD_MAX);
    alloc_word(FIELD_MAX);
  endtask

  task automatic test_random_low_limit;
    set_heap_limit(FIELD_W'($urandom_range(3000, 6000)));
    run_random(150, 150);
    // sender holds off until every outstanding word is back
    release_input;
    wait_drain;
    run_random(150, 150);
  endtask

  task automatic test_table_full;
    int guard;
    set_heap_limit(FIELD_MAX);
    guard = 0;
    while (blk_count < MAX_BLOCKS && guard < 200) begin
      alloc_word(FIELD_W'($urandom_range(5000, 6000)));
      guard++;
    end
    repeat (4) alloc_word(FIELD_W'($urandom_range(7000, 9000)));
    free_word(FIELD_W'(blk_base[MAX_BLOCKS-1] + HEADER_BYTES));
    alloc_word(blk_len[MAX_BLOCKS-1]);
  endtask

  task automatic test_random_mixed;
    run_random(250, 6000);
    burst_mode = 1'b1;
    run_random(150, 6000);
    burst_mode = 1'b0;
    set_heap_limit(FIELD_W'($urandom));
    run_random(200, 6000);
  endtask

  initial begin : result_checker
    outcome_t want;
    int       stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (outcome_q.size() == 0) begin
        report_mismatch("word with nothing pending", out_ch.status, '0);
      end else begin
        want = outcome_q.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.payload_address !== want.addr)
          report_mismatch("payload_address", out_ch.payload_address, want.addr);
        if (out_ch.reused !== want.reused)
          report_mismatch("reused", out_ch.reused, want.reused);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_ALLOC;
    in_ch.request_size <= '0;
    in_ch.free_address <= '0;
    out_ch.ready       <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    burst_mode = 1'b0;
    blk_count   = 0;
    heap_top_sh = '0;
    limit_sh    = LIMIT_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access;
    test_special_cases;
    test_limit_extremes;
    test_random_low_limit;
    test_table_full;
    test_random_mixed;

    release_input;
    wait_drain;
    repeat (MAX_BLOCKS + 8) @(posedge clk);
    $display("covered %0d request words: %0d fresh blocks, %0d reused, %0d out of space",
             n_words, n_fresh, n_reused, n_nospace);
    $display("zero sizes %0d, unknown frees %0d, double frees %0d, heap limit from 0 to max",
             n_zero, n_unknown, n_double);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
